FILE: design/akhc_pkg.sv
// Shared types and constants for the arm64 kernel header checker.
// Used by the front, queue, back and checker modules; no dependencies.
package akhc_pkg;

  localparam int COUNT_W  = 40;                  // width of the saturating byte counter
  localparam int OVL_W    = 40;                  // overlay length field width
  localparam int HDR_SIZE = 64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [7:0] MZ_M = 8'h4D;
  localparam logic [7:0] MZ_Z = 8'h5A;
  localparam logic [7:0] MAGIC [4] = '{8'h41, 8'h52, 8'h4D, 8'h64};
  localparam logic [7:0] PE_SIG [4] = '{8'h50, 8'h45, 8'h00, 8'h00};

  // header layout (byte offsets)
  localparam logic [5:0] POS_MZ_M   = 6'd0;
  localparam logic [5:0] POS_MZ_Z   = 6'd1;
  localparam logic [5:0] POS_CODE1  = 6'd4;
  localparam logic [5:0] POS_TEXT   = 6'd8;
  localparam logic [5:0] POS_SIZE   = 6'd16;
  localparam logic [5:0] POS_FLAGS  = 6'd24;
  localparam logic [5:0] POS_RSVD   = 6'd32;
  localparam logic [5:0] POS_MAGIC  = 6'd56;
  localparam logic [5:0] POS_PEOFF  = 6'd60;
  localparam logic [5:0] POS_LAST   = 6'd63;

  localparam logic [1:0] PG_NONE = 2'd0;
  localparam logic [1:0] PG_4K   = 2'd1;
  localparam logic [1:0] PG_16K  = 2'd2;
  localparam logic [1:0] PG_64K  = 2'd3;

  // result word layout on m_axis_tdata
  localparam int OUT_W         = 352;
  localparam int O_VALID       = 0;
  localparam int O_CODE0       = 1;
  localparam int O_CODE1       = 33;
  localparam int O_TEXT        = 65;
  localparam int O_SIZE        = 129;
  localparam int O_FLAGS       = 193;
  localparam int O_PEOFF       = 257;
  localparam int O_MZ          = 289;
  localparam int O_BE          = 290;
  localparam int O_PHYS        = 291;
  localparam int O_PAGE        = 292;
  localparam int O_OVL         = 309;
  localparam int O_PAD         = 349;

  // one classified byte handed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             is_hdr;    // byte lies in the 64-byte header
    logic [5:0]       pos;       // header offset, meaningful when is_hdr
    logic             sig_hit;   // byte matches PE signature at its window slot
    logic             hdr_done;  // at least 64 bytes counted including this one
    logic [OVL_W-1:0] overlay;   // bytes past the header, including this one
  } cmd_t;

endpackage

FILE: design/akhc_front.sv
// Front end: byte counter, PE offset tracking and classification of each byte.
// Depends on akhc_pkg.
module akhc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         in_data,
  input  logic               in_last,
  input  logic               q_ready,
  output logic               push,
  output akhc_pkg::cmd_t     push_cmd
);
  import akhc_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] count_next;
  logic [31:0]        sig_off;
  logic [31:0]        sig_off_next;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] sig_off_ext;
  logic [COUNT_W-1:0] diff;
  logic               is_hdr;
  logic               in_win;

  assign push = in_valid && q_ready;

  always_comb begin
    is_hdr      = (byte_count[COUNT_W-1:6] == '0);
    sig_off_ext = {{(COUNT_W-32){1'b0}}, sig_off};
    diff        = byte_count - sig_off_ext;
    in_win      = !is_hdr && (byte_count >= sig_off_ext) && (diff[COUNT_W-1:2] == '0);
    total       = (byte_count == COUNT_MAX) ? byte_count : byte_count + 1'b1;

    push_cmd.data     = in_data;
    push_cmd.last     = in_last;
    push_cmd.is_hdr   = is_hdr;
    push_cmd.pos      = byte_count[5:0];
    push_cmd.sig_hit  = in_win && (in_data == PE_SIG[diff[1:0]]);
    push_cmd.hdr_done = (total[COUNT_W-1:6] != '0);
    push_cmd.overlay  = (total > COUNT_W'(HDR_SIZE)) ?
                        OVL_W'(total - COUNT_W'(HDR_SIZE)) : '0;

    sig_off_next = sig_off;
    if (is_hdr && (byte_count[5:2] == POS_PEOFF[5:2])) begin
      sig_off_next[byte_count[1:0]*8 +: 8] = in_data;
    end
    count_next = total;
    if (in_last) begin
      count_next   = '0;
      sig_off_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      sig_off    <= '0;
    end else if (push) begin
      byte_count <= count_next;
      sig_off    <= sig_off_next;
    end
  end

endmodule

FILE: design/akhc_queue.sv
// Two-entry FIFO of classified bytes between front and back.
// Depends on akhc_pkg.
module akhc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  akhc_pkg::cmd_t push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output akhc_pkg::cmd_t pop_cmd
);
  import akhc_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/akhc_back.sv
// Back end: header field capture, header checks, signature match count,
// verdict assembly and the output register. Depends on akhc_pkg.
module akhc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  akhc_pkg::cmd_t              q_cmd,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [akhc_pkg::OUT_W-1:0]  out_data
);
  import akhc_pkg::*;

  logic [31:0] word_code0, code0_next;
  logic [31:0] word_code1, code1_next;
  logic [63:0] load_offset, load_next;
  logic [63:0] size_field, size_next;
  logic [63:0] flags_field, flags_next;
  logic [31:0] signature_offset, sig_next;
  logic        mz_seen, mz_next;
  logic        check_failed, failed_next;
  logic [2:0]  signature_matched, matched_next;
  logic        verdict;
  logic [16:0] page;
  logic [OUT_W-1:0] result;
  logic [7:0]  b;
  logic [5:0]  p;

  // a verdict may be produced only when the output register is free
  assign pop = q_valid && (!q_cmd.last || !out_valid || out_ready);

  always_comb begin
    b = q_cmd.data;
    p = q_cmd.pos;
    code0_next   = word_code0;
    code1_next   = word_code1;
    load_next    = load_offset;
    size_next    = size_field;
    flags_next   = flags_field;
    sig_next     = signature_offset;
    mz_next      = mz_seen;
    failed_next  = check_failed;
    matched_next = signature_matched;

    if (q_cmd.is_hdr) begin
      if (p == POS_MZ_M) mz_next = (b == MZ_M);
      else if (p == POS_MZ_Z) mz_next = mz_seen && (b == MZ_Z);

      priority if (p < POS_CODE1) begin
        code0_next[p[1:0]*8 +: 8] = b;
      end else if (p < POS_TEXT) begin
        code1_next[p[1:0]*8 +: 8] = b;
      end else if (p < POS_SIZE) begin
        load_next[p[2:0]*8 +: 8] = b;
      end else if (p < POS_FLAGS) begin
        size_next[p[2:0]*8 +: 8] = b;
      end else if (p < POS_RSVD) begin
        flags_next[p[2:0]*8 +: 8] = b;
      end else if (p < POS_MAGIC) begin
        if (b != 8'h00) failed_next = 1'b1;
      end else if (p < POS_PEOFF) begin
        if (b != MAGIC[p[1:0]]) failed_next = 1'b1;
      end else begin
        sig_next[p[1:0]*8 +: 8] = b;
      end

      if (p == POS_LAST) begin
        if (flags_field[63:4] != '0) failed_next = 1'b1;
        if (sig_next[31:6] == '0) failed_next = 1'b1;   // PE offset below 64
      end
    end else if (q_cmd.sig_hit && (signature_matched < 3'd4)) begin
      matched_next = signature_matched + 3'd1;
    end

    verdict = q_cmd.hdr_done && !failed_next && (matched_next == 3'd4);

    unique case (flags_next[2:1])
      PG_4K:   page = 17'd4096;
      PG_16K:  page = 17'd16384;
      PG_64K:  page = 17'd65536;
      default: page = 17'd0;
    endcase

    result = '0;
    result[O_VALID]            = verdict;
    result[O_CODE0 +: 32]      = code0_next;
    result[O_CODE1 +: 32]      = code1_next;
    result[O_TEXT  +: 64]      = load_next;
    result[O_SIZE  +: 64]      = size_next;
    result[O_FLAGS +: 64]      = flags_next;
    result[O_PEOFF +: 32]      = sig_next;
    result[O_MZ]               = mz_next;
    result[O_BE]               = flags_next[0];
    result[O_PHYS]             = flags_next[3];
    result[O_PAGE  +: 17]      = page;
    result[O_OVL   +: OVL_W]   = q_cmd.overlay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_code0        <= '0;
      word_code1        <= '0;
      load_offset       <= '0;
      size_field        <= '0;
      flags_field       <= '0;
      signature_offset  <= '0;
      mz_seen           <= 1'b0;
      check_failed      <= 1'b0;
      signature_matched <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (pop && q_cmd.last) begin
        // image done: verdict out, state back to its empty form
        word_code0        <= '0;
        word_code1        <= '0;
        load_offset       <= '0;
        size_field        <= '0;
        flags_field       <= '0;
        signature_offset  <= '0;
        mz_seen           <= 1'b0;
        check_failed      <= 1'b0;
        signature_matched <= '0;
        out_valid         <= 1'b1;
      end else begin
        if (pop) begin
          word_code0        <= code0_next;
          word_code1        <= code1_next;
          load_offset       <= load_next;
          size_field        <= size_next;
          flags_field       <= flags_next;
          signature_offset  <= sig_next;
          mz_seen           <= mz_next;
          check_failed      <= failed_next;
          signature_matched <= matched_next;
        end
        if (out_ready) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.last) begin
      out_data <= result;
    end
  end

endmodule

FILE: design/arm64_kernel_header_checker.sv
// Top level of the arm64 kernel image header checker.
// Instantiates akhc_front, akhc_queue and akhc_back; depends on akhc_pkg.
//
// Takes one image byte per transfer, header first, with tlast on the final
// byte, and sustains one byte per clock. The front counts bytes (saturating
// 40-bit counter) and tags each one as a header byte or a PE signature slot;
// a two-entry queue feeds the back, which assembles the header fields, runs
// the checks and loads the verdict into an output register. m_axis_tvalid
// rises when the back pops the last byte from the queue and registers the verdict.
// Input stalls only when a verdict is still held in the output register and
// the next image's last byte reaches the back; the queue then fills and
// tready drops. Until then bytes keep flowing.
module arm64_kernel_header_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
  input  logic                        s_axis_tlast,   // last_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [0] image_valid, [32:1] code0, [64:33] code1, [128:65] load_offset,
  // [192:129] size_field, [256:193] flag_word, [288:257] signature_offset,
  // [289] has_mz, [290] big_endian, [291] phys_anywhere,
  // [308:292] page_bytes, [348:309] tail_bytes, [351:349] zero
  output logic [akhc_pkg::OUT_W-1:0]  m_axis_tdata
);
  import akhc_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_ready;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  assign s_axis_tready = q_ready;

  akhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_data  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_ready  (q_ready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  akhc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd)
  );

  akhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: design/akhc_checker.sv
// Port-level checks for arm64_kernel_header_checker, attached by bind.
// Depends on akhc_pkg.
module akhc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [akhc_pkg::OUT_W-1:0]  m_axis_tdata
);
  import akhc_pkg::*;

  logic        ok;
  logic [63:0] flags;
  logic [31:0] pe_off;
  logic [16:0] page;
  logic [OVL_W-1:0] overlay;

  assign ok      = m_axis_tdata[O_VALID];
  assign flags   = m_axis_tdata[O_FLAGS +: 64];
  assign pe_off  = m_axis_tdata[O_PEOFF +: 32];
  assign page    = m_axis_tdata[O_PAGE +: 17];
  assign overlay = m_axis_tdata[O_OVL +: OVL_W];

  // a held verdict keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // a passing image carries a PE offset past the header and clean flags
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ok |-> pe_off >= 32'd64 && flags[63:4] == '0)
    else $error("passing verdict with bad header fields");

  // the signature sits past the header, so a pass means at least four overlay bytes
  a_ovl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ok |-> overlay >= OVL_W'(4))
    else $error("passing verdict with too short a stream");

  // page size follows flag bits 2:1
  a_page: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (flags[2:1] == PG_NONE && page == 17'd0) ||
                      (flags[2:1] == PG_4K && page == 17'd4096) ||
                      (flags[2:1] == PG_16K && page == 17'd16384) ||
                      (flags[2:1] == PG_64K && page == 17'd65536))
    else $error("page size does not match flags");

endmodule

bind arm64_kernel_header_checker akhc_checker u_akhc_checker (.*);
